// File: rtl/framed_packet_receiver_assert.svh
// ----------------------------------------------------------------------------
// Framed packet receiver assertion macros
// Concurrent assertion wrappers shared by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define FPR_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle outside reset.
`define FPR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Shared constants, types and the CRC-8 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 256;
  localparam int BYTE_W               = 8;
  localparam int LEN_W                = 16;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] CRC_MSB     = 8'h80;

  localparam logic [LEN_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_H1   = 3'd0,
    PH_H2   = 3'd1,
    PH_TYPE = 3'd2,
    PH_LENL = 3'd3,
    PH_LENH = 3'd4,
    PH_PAY  = 3'd5,
    PH_CRC  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_OVERSIZE = 2'd2
  } status_t;

  typedef enum logic {
    CMD_RECEIVE = 1'b0,
    CMD_READ    = 1'b1
  } command_t;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        status;
    logic [BYTE_W-1:0] ftype;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data;
  } out_item_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 8'd0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/fpr_ram.sv
// ----------------------------------------------------------------------------
// Framed packet receiver RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// Framed packet receiver
// Parses sync/type/length/payload/CRC-8 frames and serves payload reads.
// ----------------------------------------------------------------------------
// The input channel carries one command per transfer: either a received
// serial byte or a read of a stored payload byte. Bytes are parsed for frames
// of 0xAA 0x55, type, 16-bit little-endian length, payload and a CRC-8 byte.
// The frame's last byte yields a report transfer; a read yields a data
// transfer; other bytes yield nothing. A result goes to the output channel
// through the result stage register, which lines up with the registered
// read of the payload RAM. One input transfer is taken every cycle while
// in_stall is low. Results pass through a three-entry output queue, so the
// block keeps accepting while the receiver stalls, until the queue and the
// stage in front of it hold three results; then in_stall rises until the
// receiver takes one. Reset returns the parser to the hunt for 0xAA and
// empties the queue. The payload RAM is not cleared; reads are bounded by
// the stored byte count of the current or last frame.
// ----------------------------------------------------------------------------
`default_nettype none
`include "framed_packet_receiver_assert.svh"

module framed_packet_receiver #(
  parameter int BUFFER_DEPTH = fpr_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [7:0]  in_read_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [1:0]       out_frame_status,
  output logic [7:0]       out_frame_type,
  output logic [15:0]      out_frame_length,
  output logic [7:0]       out_read_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [fpr_pkg::LEN_W-1:0] DEPTH_W = fpr_pkg::LEN_W'(BUFFER_DEPTH);
  localparam int QDEPTH = 3;
  localparam logic [1:0] QLAST = 2'(QDEPTH - 1);
  localparam logic [1:0] QFULL = 2'(QDEPTH);

  fpr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  crc_r, crc_nxt;

  logic                 s1_valid_r, s1_valid_nxt;
  fpr_pkg::out_item_t   s1_item_r, s1_item_nxt;
  logic                 s1_rd_ok_r, s1_rd_ok_nxt;

  fpr_pkg::out_item_t   q_mem_r [QDEPTH];
  logic [1:0]           q_wr_r, q_rd_r, q_cnt_r;
  fpr_pkg::out_item_t   q_in;

  logic              in_acc, out_pop, q_push;
  logic              is_rx, is_read;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_q;
  logic [AW+7:0]     idx_wide;
  logic [15:0]       idx_ext;
  logic [15:0]       cnt_inc;
  logic [2:0]        in_flight;

  assign in_flight = {2'b00, s1_valid_r} + {1'b0, q_cnt_r};
  assign in_stall  = (in_flight >= 3'(QDEPTH));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (q_cnt_r != 2'd0);
  assign out_pop   = out_valid && !out_stall;
  assign q_push    = s1_valid_r;

  assign is_rx   = in_acc && (in_command == fpr_pkg::CMD_RECEIVE);
  assign is_read = in_acc && (in_command == fpr_pkg::CMD_READ);

  assign idx_wide = {{AW{1'b0}}, in_read_index};
  assign idx_ext  = {8'd0, in_read_index};
  assign cnt_inc  = (cnt_r < fpr_pkg::COUNT_MAX) ? cnt_r + 16'd1 : cnt_r;

  always_comb begin
    phase_nxt = phase_r;
    if (is_rx) begin
      case (phase_r)
        fpr_pkg::PH_H2:   phase_nxt = (in_rx_byte == fpr_pkg::SYNC_SECOND) ?
                                      fpr_pkg::PH_TYPE : fpr_pkg::PH_H1;
        fpr_pkg::PH_TYPE: phase_nxt = fpr_pkg::PH_LENL;
        fpr_pkg::PH_LENL: phase_nxt = fpr_pkg::PH_LENH;
        fpr_pkg::PH_LENH: phase_nxt = ({in_rx_byte, len_r[7:0]} == 16'd0) ?
                                      fpr_pkg::PH_CRC : fpr_pkg::PH_PAY;
        fpr_pkg::PH_PAY:  phase_nxt = (cnt_inc >= len_r) ? fpr_pkg::PH_CRC : fpr_pkg::PH_PAY;
        fpr_pkg::PH_CRC:  phase_nxt = fpr_pkg::PH_H1;
        default:          phase_nxt = (in_rx_byte == fpr_pkg::SYNC_FIRST) ?
                                      fpr_pkg::PH_H2 : fpr_pkg::PH_H1;
      endcase
    end
  end

  always_comb begin
    type_nxt     = type_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    ram_we       = 1'b0;
    ram_waddr    = cnt_r[AW-1:0];
    s1_valid_nxt = 1'b0;
    s1_rd_ok_nxt = 1'b0;
    s1_item_nxt  = '0;
    if (is_read) begin
      s1_valid_nxt     = 1'b1;
      s1_item_nxt.kind = fpr_pkg::KIND_READ;
      s1_rd_ok_nxt     = (idx_ext < cnt_r) && (idx_ext < DEPTH_W);
    end else if (is_rx) begin
      case (phase_r)
        fpr_pkg::PH_TYPE: begin
          type_nxt = in_rx_byte;
          crc_nxt  = fpr_pkg::crc8_step(8'd0, in_rx_byte);
        end
        fpr_pkg::PH_LENL: begin
          len_nxt = {8'd0, in_rx_byte};
          crc_nxt = fpr_pkg::crc8_step(crc_r, in_rx_byte);
        end
        fpr_pkg::PH_LENH: begin
          len_nxt = {in_rx_byte, len_r[7:0]};
          crc_nxt = fpr_pkg::crc8_step(crc_r, in_rx_byte);
          cnt_nxt = 16'd0;
        end
        fpr_pkg::PH_PAY: begin
          ram_we  = (cnt_r < DEPTH_W);
          crc_nxt = fpr_pkg::crc8_step(crc_r, in_rx_byte);
          cnt_nxt = cnt_inc;
        end
        fpr_pkg::PH_CRC: begin
          s1_valid_nxt       = 1'b1;
          s1_item_nxt.kind   = fpr_pkg::KIND_REPORT;
          s1_item_nxt.ftype  = type_r;
          s1_item_nxt.length = len_r;
          if (len_r > DEPTH_W) begin
            s1_item_nxt.status = fpr_pkg::ST_OVERSIZE;
          end else if (in_rx_byte == crc_r) begin
            s1_item_nxt.status = fpr_pkg::ST_GOOD;
          end else begin
            s1_item_nxt.status = fpr_pkg::ST_CRC_BAD;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ram_re    = is_read;
  assign ram_raddr = idx_wide[AW-1:0];

  fpr_ram #(
    .WIDTH (fpr_pkg::BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_comb begin
    q_in      = s1_item_r;
    q_in.data = s1_rd_ok_r ? ram_q : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= fpr_pkg::PH_H1;
      type_r     <= 8'd0;
      len_r      <= 16'd0;
      cnt_r      <= 16'd0;
      crc_r      <= 8'd0;
      s1_valid_r <= 1'b0;
      q_wr_r     <= 2'd0;
      q_rd_r     <= 2'd0;
      q_cnt_r    <= 2'd0;
    end else begin
      phase_r    <= phase_nxt;
      type_r     <= type_nxt;
      len_r      <= len_nxt;
      cnt_r      <= cnt_nxt;
      crc_r      <= crc_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (q_push) begin
        q_wr_r <= (q_wr_r == QLAST) ? 2'd0 : q_wr_r + 2'd1;
      end
      if (out_pop) begin
        q_rd_r <= (q_rd_r == QLAST) ? 2'd0 : q_rd_r + 2'd1;
      end
      if (q_push && !out_pop) begin
        q_cnt_r <= q_cnt_r + 2'd1;
      end else if (!q_push && out_pop) begin
        q_cnt_r <= q_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    s1_rd_ok_r <= s1_rd_ok_nxt;
    if (q_push) begin
      q_mem_r[q_wr_r] <= q_in;
    end
  end

  assign out_result_kind  = q_mem_r[q_rd_r].kind;
  assign out_frame_status = q_mem_r[q_rd_r].status;
  assign out_frame_type   = q_mem_r[q_rd_r].ftype;
  assign out_frame_length = q_mem_r[q_rd_r].length;
  assign out_read_data    = q_mem_r[q_rd_r].data;

  `FPR_ASSERT_ALWAYS(a_queue_room, clk, rst_n, !(s1_valid_r && q_cnt_r == QFULL),
    "result stage holds a result while the output queue is full")
  `FPR_ASSERT_IMPLY(a_pay_nonzero, clk, rst_n, phase_r == fpr_pkg::PH_PAY, len_r != 16'd0,
    "payload phase entered with zero declared length")
  `FPR_ASSERT_IMPLY(a_pay_count, clk, rst_n, phase_r == fpr_pkg::PH_PAY, cnt_r < len_r,
    "payload phase with byte count at or past declared length")
  `FPR_ASSERT_IMPLY(a_good_fits, clk, rst_n,
    s1_valid_r && s1_item_r.kind == fpr_pkg::KIND_REPORT && s1_item_r.status == fpr_pkg::ST_GOOD,
    s1_item_r.length <= DEPTH_W, "good report for a frame longer than the buffer")

endmodule

`default_nettype wire

// File: bench/framed_packet_receiver_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver checker
// Watches both channels of the receiver and keeps its own model of the frame
// parser and the payload store. Each input transfer updates that model. The
// results it predicts wait in order, and each result transfer is compared
// field by field with the oldest one. The checker counts the errors it finds
// and reports how many predicted results are still waiting.
// ----------------------------------------------------------------------------
module framed_packet_receiver_checker #(
  parameter int BUFFER_DEPTH = fpr_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_read_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_result_kind,
  input  logic [1:0]  out_frame_status,
  input  logic [7:0]  out_frame_type,
  input  logic [15:0] out_frame_length,
  input  logic [7:0]  out_read_data,
  output int          error_count,
  output int          outstanding
);

  fpr_pkg::phase_t     parse_state;
  logic [7:0]          type_held;
  logic [15:0]         length_declared;
  logic [15:0]         payload_count;
  logic [7:0]          crc_acc;
  logic [7:0]          payload_copy [BUFFER_DEPTH];
  fpr_pkg::out_item_t  predicted_results [$];

  function automatic logic [7:0] crc_update(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((c & fpr_pkg::CRC_MSB) != 8'd0) begin
        c = (c << 1) ^ fpr_pkg::CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  function automatic void predict_transfer(input logic cmd, input logic [7:0] b,
                                           input logic [7:0] idx);
    fpr_pkg::out_item_t r;
    int stored;
    r = '0;
    if (cmd == fpr_pkg::CMD_READ) begin
      stored = (payload_count > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(payload_count);
      r.kind = fpr_pkg::KIND_READ;
      if (idx < stored) begin
        r.data = payload_copy[idx];
      end
      predicted_results.push_back(r);
    end else begin
      case (parse_state)
        fpr_pkg::PH_H2: begin
          parse_state = (b == fpr_pkg::SYNC_SECOND) ? fpr_pkg::PH_TYPE : fpr_pkg::PH_H1;
        end
        fpr_pkg::PH_TYPE: begin
          type_held = b;
          crc_acc = crc_update(8'h00, b);
          parse_state = fpr_pkg::PH_LENL;
        end
        fpr_pkg::PH_LENL: begin
          length_declared = {8'h00, b};
          crc_acc = crc_update(crc_acc, b);
          parse_state = fpr_pkg::PH_LENH;
        end
        fpr_pkg::PH_LENH: begin
          length_declared[15:8] = b;
          crc_acc = crc_update(crc_acc, b);
          payload_count = '0;
          parse_state = (length_declared == 16'd0) ? fpr_pkg::PH_CRC : fpr_pkg::PH_PAY;
        end
        fpr_pkg::PH_PAY: begin
          if (payload_count < BUFFER_DEPTH) begin
            payload_copy[payload_count] = b;
          end
          crc_acc = crc_update(crc_acc, b);
          if (payload_count != fpr_pkg::COUNT_MAX) begin
            payload_count = payload_count + 16'd1;
          end
          if (payload_count >= length_declared) begin
            parse_state = fpr_pkg::PH_CRC;
          end
        end
        fpr_pkg::PH_CRC: begin
          r.kind = fpr_pkg::KIND_REPORT;
          if (length_declared > BUFFER_DEPTH) begin
            r.status = fpr_pkg::ST_OVERSIZE;
          end else if (b == crc_acc) begin
            r.status = fpr_pkg::ST_GOOD;
          end else begin
            r.status = fpr_pkg::ST_CRC_BAD;
          end
          r.ftype = type_held;
          r.length = length_declared;
          predicted_results.push_back(r);
          parse_state = fpr_pkg::PH_H1;
        end
        default: begin
          parse_state = (b == fpr_pkg::SYNC_FIRST) ? fpr_pkg::PH_H2 : fpr_pkg::PH_H1;
        end
      endcase
    end
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    fpr_pkg::out_item_t want;
    if (!rst_n) begin
      parse_state = fpr_pkg::PH_H1;
      type_held = '0;
      length_declared = '0;
      payload_count = '0;
      crc_acc = '0;
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        payload_copy[i] = '0;
      end
      predicted_results.delete();
      error_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual kind %0d data %0d",
                   $time, out_result_kind, out_read_data);
        end else begin
          want = predicted_results.pop_front();
          check_field("result_kind", want.kind, out_result_kind);
          check_field("frame_status", want.status, out_frame_status);
          check_field("frame_type", want.ftype, out_frame_type);
          check_field("frame_length", want.length, out_frame_length);
          check_field("read_data", want.data, out_read_data);
        end
      end
      if (in_valid && !in_stall) begin
        predict_transfer(in_command, in_rx_byte, in_read_index);
      end
    end
    outstanding = predicted_results.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver testbench
// Drives the receiver with serial bytes and payload reads: a short directed
// opening for lost headers, zero length frames, bad CRC and reads around the
// stored data, then random well-formed frames of mostly small lengths with
// some full and oversize ones, read bursts, noise and broken headers. The
// sender idles and the receiver stalls at random. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH     = fpr_pkg::DEFAULT_BUFFER_DEPTH;
  localparam int RUN_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic [7:0]  in_read_index = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [1:0]  out_frame_status;
  logic [7:0]  out_frame_type;
  logic [15:0] out_frame_length;
  logic [7:0]  out_read_data;

  int error_count;
  int outstanding;
  int cycle_count = 0;
  int item_total = 0;
  bit sender_calm = 1'b0;

  always #5 clk = ~clk;

  framed_packet_receiver #(.BUFFER_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_rx_byte(in_rx_byte), .in_read_index(in_read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(out_result_kind), .out_frame_status(out_frame_status),
    .out_frame_type(out_frame_type), .out_frame_length(out_frame_length),
    .out_read_data(out_read_data)
  );

  framed_packet_receiver_checker #(.BUFFER_DEPTH(DEPTH)) result_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_rx_byte(in_rx_byte), .in_read_index(in_read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(out_result_kind), .out_frame_status(out_frame_status),
    .out_frame_type(out_frame_type), .out_frame_length(out_frame_length),
    .out_read_data(out_read_data),
    .error_count(error_count), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("framed_packet_receiver verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_index();
    return ($urandom_range(0, 3) == 0) ? rand_byte() : 8'($urandom_range(0, 31));
  endfunction

  task automatic issue(input fpr_pkg::command_t cmd, input logic [7:0] b,
                       input logic [7:0] idx);
    int gap;
    int r;
    item_total++;
    if ($urandom_range(0, 49) == 0) begin
      sender_calm = !sender_calm;
    end
    r = $urandom_range(0, 99);
    gap = 0;
    if (!sender_calm) begin
      if (r >= 92) begin
        gap = $urandom_range(8, 40);
      end else if (r >= 70) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= b;
    in_read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    issue(fpr_pkg::CMD_RECEIVE, b, rand_byte());
  endtask

  task automatic read_byte(input logic [7:0] idx);
    issue(fpr_pkg::CMD_READ, rand_byte(), idx);
  endtask

  task automatic send_frame(input logic [7:0] ftype, input int len, input bit corrupt,
                            input int read_pct);
    logic [7:0] crc;
    logic [7:0] b;
    logic [15:0] len_bits;
    len_bits = 16'(len);
    push_byte(fpr_pkg::SYNC_FIRST);
    push_byte(fpr_pkg::SYNC_SECOND);
    push_byte(ftype);
    crc = fpr_pkg::crc8_step(8'h00, ftype);
    push_byte(len_bits[7:0]);
    crc = fpr_pkg::crc8_step(crc, len_bits[7:0]);
    push_byte(len_bits[15:8]);
    crc = fpr_pkg::crc8_step(crc, len_bits[15:8]);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < read_pct) begin
        read_byte(pick_index());
      end
      b = rand_byte();
      push_byte(b);
      crc = fpr_pkg::crc8_step(crc, b);
    end
    if (corrupt) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    push_byte(crc);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin : result_backpressure
    int hold;
    int r;
    bit calm;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 19) == 0) begin
        calm = !calm;
      end
      r = $urandom_range(0, 99);
      if (calm || r < 60) begin
        out_stall <= 1'b0;
        hold = calm ? $urandom_range(1, 60) : $urandom_range(1, 4);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        hold = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        hold = $urandom_range(10, 30);
      end
      repeat (hold - 1) @(posedge clk);
    end
  end

  initial begin : stimulus
    int r;
    int len;
    logic [7:0] b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    read_byte(8'd0);
    push_byte(fpr_pkg::SYNC_FIRST);
    push_byte(8'h13);
    push_byte(fpr_pkg::SYNC_FIRST);
    push_byte(fpr_pkg::SYNC_FIRST);
    push_byte(fpr_pkg::SYNC_SECOND);
    send_frame(8'hFF, 0, 1'b0, 0);
    send_frame(8'h5A, 2, 1'b1, 100);
    read_byte(8'd1);
    read_byte(8'd2);
    read_byte(8'hFF);
    wait_for_drain();

    send_frame(rand_byte(), DEPTH, 1'($urandom_range(0, 1)), 5);
    send_frame(rand_byte(), DEPTH + 1, 1'($urandom_range(0, 1)), 5);
    while (item_total < 1200) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          len = $urandom_range(0, 24);
        end else if (r < 90) begin
          len = $urandom_range(25, DEPTH - 1);
        end else if (r < 95) begin
          len = $urandom_range(DEPTH - 1, DEPTH + 1);
        end else begin
          len = $urandom_range(DEPTH + 2, 700);
        end
        send_frame(rand_byte(), len, $urandom_range(0, 3) == 0, 15);
      end else if (r < 77) begin
        repeat ($urandom_range(1, 6)) read_byte(pick_index());
      end else if (r < 87) begin
        repeat ($urandom_range(1, 8)) begin
          push_byte(($urandom_range(0, 3) == 0) ? fpr_pkg::SYNC_FIRST : rand_byte());
        end
        push_byte(8'h00);
      end else begin
        b = rand_byte();
        if (b == fpr_pkg::SYNC_SECOND) begin
          b = fpr_pkg::SYNC_FIRST;
        end
        push_byte(fpr_pkg::SYNC_FIRST);
        push_byte(b);
      end
      if ($urandom_range(0, 49) == 0) begin
        wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("framed_packet_receiver verification clean");
    end else begin
      $display("framed_packet_receiver verification failed");
    end
    $finish;
  end

endmodule
